[rtl/core/interleaved_stride_address_remapper_defines.svh]
// Assertion macros for the address remapper
`ifndef INTERLEAVED_STRIDE_ADDRESS_REMAPPER_DEFINES_SVH
`define INTERLEAVED_STRIDE_ADDRESS_REMAPPER_DEFINES_SVH
// implication checked on every clock, quiet in reset
`define ISAR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ISAR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/core/isar_pkg.sv]
// ----------------------------------------------------------------------------
// isar_pkg
// Shared types and constants for the interleaved stride address remapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package isar_pkg;
    localparam int SeenDepthDefault = 256;
    localparam logic [3:0] ModeOne   = 4'hC;
    localparam logic [3:0] ModeTwo   = 4'hD;
    localparam logic [3:0] ModeThree = 4'hF;
    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StZero = 2'd1;
    localparam logic [1:0] StMode = 2'd2;
    localparam logic [1:0] StFull = 2'd3;
    localparam logic [2:0] RegBase  = 3'd0;
    localparam logic [2:0] RegIntl2 = 3'd1;
    localparam logic [2:0] RegIntl3 = 3'd2;
    localparam logic [2:0] RegOuter = 3'd3;
    localparam logic [2:0] RegMode  = 3'd4;
    localparam logic [2:0] RegDest  = 3'd5;
    localparam logic [63:0] SlotBytes = 64'd8;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_CMP, ST_DONE, ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic restart;   // load on restart transfer
        logic begin_el;  // latch element, start search
        logic step;      // advance search index
        logic finish;    // compute result and update state
        logic out_take;  // result taken
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic running;
        logic bad;       // error result pending on restart/advance
        logic srch_end;  // search exhausted or matched
    } sts_t;
endpackage

[rtl/core/isar_datapath.sv]
// ----------------------------------------------------------------------------
// isar_datapath
// Stream address state, seen-table memory and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module isar_datapath #(
    parameter int SEEN_DEPTH = isar_pkg::SeenDepthDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_wr_index,
    input  logic [47:0]       cfg_wr_data,
    input  isar_pkg::cmd_t    cmd,
    output isar_pkg::sts_t    sts,
    output logic [199:0]      res_data
);
    localparam int AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int CW = $clog2(SEEN_DEPTH + 1);

    logic [47:0] base_reg, mode_reg, dest_reg;
    logic [31:0] i2_reg, i3_reg, ol_reg;
    logic [63:0] cur_reg [3];
    logic [63:0] ps_reg [3];
    logic [63:0] free_reg, src_reg;
    logic [CW-1:0] cnt_reg, idx_reg;
    logic [15:0] oit_reg, ec_reg;
    logic [1:0]  lane_reg;
    logic        run_reg, found_reg;
    logic [63:0] mem [SEEN_DEPTH];
    logic [63:0] rd_reg;
    logic [199:0] res_reg;

    logic [15:0] length;
    logic [1:0]  lanes;
    logic [1:0]  ln;
    assign length = mode_reg[15:0];
    always_comb begin
        case (mode_reg[19:16])
            isar_pkg::ModeOne:   lanes = 2'd1;
            isar_pkg::ModeTwo:   lanes = 2'd2;
            isar_pkg::ModeThree: lanes = 2'd3;
            default:             lanes = 2'd0;
        endcase
    end
    assign ln = (lane_reg >= lanes) ? 2'd0 : lane_reg;

    assign sts.running  = run_reg;
    assign sts.bad      = (length == 16'd0) || (lanes == 2'd0);
    assign sts.srch_end = found_reg || (idx_reg >= cnt_reg);
    assign res_data = res_reg;

    function automatic logic [63:0] sx(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    logic [63:0] stride;
    always_comb begin
        case (ln)
            2'd0:    stride = sx(mode_reg[47:32]);
            2'd1:    stride = sx(i2_reg[31:16]);
            default: stride = sx(i3_reg[31:16]);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0; i2_reg <= '0; i3_reg <= '0;
            ol_reg <= '0; mode_reg <= '0; dest_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                isar_pkg::RegBase:  base_reg <= cfg_wr_data;
                isar_pkg::RegIntl2: i2_reg   <= cfg_wr_data[31:0];
                isar_pkg::RegIntl3: i3_reg   <= cfg_wr_data[31:0];
                isar_pkg::RegOuter: ol_reg   <= cfg_wr_data[31:0];
                isar_pkg::RegMode:  mode_reg <= cfg_wr_data;
                isar_pkg::RegDest:  dest_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[idx_reg[AW-1:0]];
        if (cmd.finish && !found_reg && cnt_reg < CW'(SEEN_DEPTH))
            mem[cnt_reg[AW-1:0]] <= src_reg;
    end

    logic [63:0] off;
    logic [15:0] olen;
    logic [15:0] ec_n;
    logic [1:0]  lane_n;
    logic        full;
    logic        pass_end, pass_last;
    assign off  = {48'd0, ol_reg[31:16]};
    assign olen = (ol_reg[15:0] == 16'd0) ? 16'd1 : ol_reg[15:0];
    assign ec_n = ec_reg + 16'd1;
    assign lane_n = (ln + 2'd1 >= lanes) ? 2'd0 : ln + 2'd1;
    assign full = !found_reg && (cnt_reg >= CW'(SEEN_DEPTH));
    assign pass_end  = (ec_n >= length);
    assign pass_last = pass_end && (oit_reg + 16'd1 >= olen);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; free_reg <= '0; oit_reg <= '0; ec_reg <= '0;
            lane_reg <= '0; run_reg <= 1'b0; idx_reg <= '0; found_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                cur_reg[k] <= '0; ps_reg[k] <= '0;
            end
        end else if (cmd.restart) begin
            cnt_reg <= '0; free_reg <= {16'd0, dest_reg};
            ps_reg[0] <= {16'd0, base_reg};
            ps_reg[1] <= {16'd0, base_reg} + {48'd0, i2_reg[15:0]};
            ps_reg[2] <= {16'd0, base_reg} + {48'd0, i3_reg[15:0]};
            cur_reg[0] <= {16'd0, base_reg};
            cur_reg[1] <= {16'd0, base_reg} + {48'd0, i2_reg[15:0]};
            cur_reg[2] <= {16'd0, base_reg} + {48'd0, i3_reg[15:0]};
            oit_reg <= '0; ec_reg <= '0; lane_reg <= '0;
            run_reg <= !sts.bad;
            res_reg <= {4'd0, 16'd0, dest_reg,
                        2'(length == 16'd0 ? isar_pkg::StZero : isar_pkg::StMode),
                        1'b0, 1'b0, 64'd0, 64'd0};
        end else if (cmd.begin_el) begin
            if (sts.bad) begin
                run_reg <= 1'b0;
                res_reg <= {4'd0, free_reg,
                            2'(length == 16'd0 ? isar_pkg::StZero : isar_pkg::StMode),
                            1'b0, 1'b0, 64'd0, 64'd0};
            end
            lane_reg <= ln;
            src_reg <= cur_reg[ln];
            idx_reg <= '0;
            found_reg <= 1'b0;
        end else if (cmd.step) begin
            if (idx_reg < cnt_reg && rd_reg == src_reg) found_reg <= 1'b1;
            else idx_reg <= idx_reg + CW'(1);
        end else if (cmd.finish) begin
            if (full) begin
                run_reg <= 1'b0;
                res_reg <= {4'd0, free_reg, isar_pkg::StFull, 1'b0, 1'b0, 64'd0, src_reg};
            end else begin
                if (!found_reg) begin
                    cnt_reg <= cnt_reg + CW'(1);
                    free_reg <= free_reg + isar_pkg::SlotBytes;
                end
                res_reg <= {4'd0,
                            found_reg ? free_reg : free_reg + isar_pkg::SlotBytes,
                            isar_pkg::StOk, pass_last, !found_reg,
                            found_reg ? 64'd0 : free_reg, src_reg};
                if (pass_end) begin
                    for (int k = 0; k < 3; k++) begin
                        if (k < int'(lanes)) begin
                            ps_reg[k] <= ps_reg[k] + off;
                            cur_reg[k] <= ps_reg[k] + off;
                        end else begin
                            cur_reg[k] <= ps_reg[k];
                        end
                    end
                    ec_reg <= '0; lane_reg <= '0;
                    oit_reg <= oit_reg + 16'd1;
                    if (pass_last) run_reg <= 1'b0;
                end else begin
                    cur_reg[ln] <= src_reg + stride;
                    lane_reg <= lane_n;
                    ec_reg <= ec_n;
                end
            end
        end
    end
endmodule

[rtl/core/isar_ctrl.sv]
// ----------------------------------------------------------------------------
// isar_ctrl
// Sequencer: accepts a transfer, runs the table search, presents the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module isar_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            in_restart,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  isar_pkg::sts_t  sts,
    output isar_pkg::cmd_t  cmd
);
    isar_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= isar_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            isar_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_restart) begin
                        cmd.restart = 1'b1;
                        if (sts.bad) state_next = isar_pkg::ST_OUT;
                    end else if (sts.running) begin
                        cmd.begin_el = 1'b1;
                        state_next = sts.bad ? isar_pkg::ST_OUT : isar_pkg::ST_RD;
                    end
                end
            end
            isar_pkg::ST_RD: state_next = isar_pkg::ST_CMP;
            isar_pkg::ST_CMP: begin
                if (sts.srch_end) state_next = isar_pkg::ST_DONE;
                else begin
                    cmd.step = 1'b1;
                    state_next = isar_pkg::ST_RD;
                end
            end
            isar_pkg::ST_DONE: begin
                cmd.finish = 1'b1;
                state_next = isar_pkg::ST_OUT;
            end
            isar_pkg::ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.out_take = 1'b1;
                    state_next = isar_pkg::ST_IDLE;
                end
            end
            default: state_next = isar_pkg::ST_IDLE;
        endcase
    end
endmodule

[rtl/core/interleaved_stride_address_remapper.sv]
// ----------------------------------------------------------------------------
// interleaved_stride_address_remapper
// Strided interleaved source walk with packed destination slot assignment.
// ----------------------------------------------------------------------------
// One input transfer per element. An advancing element reads the seen-table entries
// one at a time through the single read port of the seen-table memory and compares
// them up to a match or the end (up to SEEN_DEPTH entries), then presents the
// output transfer; a restart runs no search. The table needs no clearing.
`timescale 1ns / 1ps
`include "interleaved_stride_address_remapper_defines.svh"
module interleaved_stride_address_remapper #(
    parameter int SEEN_DEPTH = isar_pkg::SeenDepthDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_index,
    input  logic [47:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // restart
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // src_addr, dst_addr, is_new, status, next_free_addr
    output logic         m_tlast    // last_elem
);
    isar_pkg::cmd_t cmd;
    isar_pkg::sts_t sts;
    logic [199:0] res;

    isar_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_restart(s_tdata[0]),
        .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
        .sts, .cmd
    );
    isar_datapath #(.SEEN_DEPTH(SEEN_DEPTH)) u_dp (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_index, .cfg_wr_data,
        .cmd, .sts, .res_data(res)
    );
    // tdata without last_elem: src, dst, is_new, status, next_free
    assign m_tdata = {5'd0, res[195:132], res[131:130], res[128:0]};
    assign m_tlast = res[129];

    `ISAR_ASSERT_IMP(a_excl, aclk, aresetn, 1'b1, !(s_tready && m_tvalid), "ready with result")
    `ISAR_ASSERT_NXT(a_fin, aclk, aresetn, cmd.finish, m_tvalid, "finish without result")
endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the interleaved stride address remapper: a directed
// table followed by randomised setup phases, with every result compared
// against a behavioural copy of the stream walk and the seen-table lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;

    localparam int DEPTH = isar_pkg::SeenDepthDefault;
    localparam int DRAIN_CYCLES = 2 * (DEPTH + 1) + 80;
    localparam int N_ITEMS = 1200;

    typedef struct packed {
        logic [63:0] src;
        logic [63:0] dst;
        logic        is_new;
        logic        last;
        logic [1:0]  status;
        logic [63:0] next_free;
    } remap_t;

    typedef struct packed {
        bit          wr;
        logic [2:0]  idx;
        logic [47:0] val;
        bit          rs;
        bit          chk;
        bit          has;
        logic [1:0]  st;
        logic [63:0] src;
    } row_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_wr_en = 0;
    logic [2:0]   cfg_wr_index = '0;
    logic [47:0]  cfg_wr_data = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [199:0] m_tdata;
    logic         m_tlast;

    interleaved_stride_address_remapper dut (.*);

    always #5 aclk = ~aclk;

    // register copies
    logic [47:0] r_base, r_mode, r_dest;
    logic [31:0] r_intl2, r_intl3, r_outer;
    // walk state
    logic [63:0] seen_addrs [DEPTH];
    int unsigned seen_cnt;
    logic [63:0] walk_addr [3];
    logic [63:0] pass_start [3];
    logic [63:0] free_slot;
    logic [15:0] pass_iter, elem_cnt;
    int unsigned lane;
    bit          walking;

    remap_t      remap_q [$];
    remap_t      last_remap;
    bit          last_has;
    int          n_errors = 0;
    int          n_items = 0;
    bit          quiet = 0;
    bit          hold_req = 0;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic int unsigned lanes_of(input logic [3:0] m);
        case (m)
            isar_pkg::ModeOne:   return 1;
            isar_pkg::ModeTwo:   return 2;
            isar_pkg::ModeThree: return 3;
            default:             return 0;
        endcase
    endfunction

    function automatic logic [63:0] stride_of(input int unsigned ln);
        if (ln == 0) return sx16(r_mode[47:32]);
        if (ln == 1) return sx16(r_intl2[31:16]);
        return sx16(r_intl3[31:16]);
    endfunction

    task automatic remap_step(input bit rs, output bit has, output remap_t r);
        logic [15:0] len;
        int unsigned nl;
        logic [63:0] src;
        bit          hit;
        logic [15:0] cnt;
        len = r_mode[15:0];
        nl  = lanes_of(r_mode[19:16]);
        has = 0;
        r   = '0;
        hit = 0;
        if (rs) begin
            seen_cnt = 0;
            free_slot = {16'd0, r_dest};
            pass_start[0] = {16'd0, r_base};
            pass_start[1] = {16'd0, r_base} + r_intl2[15:0];
            pass_start[2] = {16'd0, r_base} + r_intl3[15:0];
            walk_addr = pass_start;
            pass_iter = 0; elem_cnt = 0; lane = 0;
            walking = 0;
            r.next_free = free_slot;
            if (len == 0) begin
                has = 1; r.status = isar_pkg::StZero;
            end else if (nl == 0) begin
                has = 1; r.status = isar_pkg::StMode;
            end else begin
                walking = 1;
            end
            return;
        end
        if (!walking) return;
        has = 1;
        r.next_free = free_slot;
        if (len == 0) begin
            walking = 0; r.status = isar_pkg::StZero; return;
        end
        if (nl == 0) begin
            walking = 0; r.status = isar_pkg::StMode; return;
        end
        if (lane >= nl) lane = 0;
        src = walk_addr[lane];
        r.src = src;
        for (int i = 0; i < seen_cnt; i++)
            if (seen_addrs[i] == src) hit = 1;
        if (!hit) begin
            if (seen_cnt >= DEPTH) begin
                walking = 0; r.status = isar_pkg::StFull; return;
            end
            seen_addrs[seen_cnt] = src;
            seen_cnt++;
            r.dst = free_slot;
            r.is_new = 1;
            free_slot += isar_pkg::SlotBytes;
        end
        walk_addr[lane] = src + stride_of(lane);
        elem_cnt++;
        lane++;
        if (lane >= nl) lane = 0;
        if (elem_cnt >= len) begin
            for (int i = 0; i < nl; i++) pass_start[i] += r_outer[31:16];
            walk_addr = pass_start;
            elem_cnt = 0; lane = 0;
            pass_iter++;
            cnt = (r_outer[15:0] == 0) ? 16'd1 : r_outer[15:0];
            if (pass_iter >= cnt) begin
                r.last = 1; walking = 0;
            end
        end
        r.next_free = free_slot;
        r.status = isar_pkg::StOk;
    endtask

    task automatic send_item(input bit rs);
        @(negedge aclk);
        s_tdata = {7'd0, rs};
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        remap_step(rs, last_has, last_remap);
        if (last_has) remap_q.push_back(last_remap);
        n_items++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_tvalid = 0;
            repeat ($urandom_range(1, 19) - 1) @(negedge aclk);
        end
    endtask

    // wait for every result, then for the block to settle
    task automatic drain;
        @(negedge aclk);
        s_tvalid = 0;
        while (remap_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(negedge aclk);
        cfg_wr_en = 1; cfg_wr_index = idx; cfg_wr_data = val;
        case (idx)
            isar_pkg::RegBase:  r_base  = val;
            isar_pkg::RegIntl2: r_intl2 = val[31:0];
            isar_pkg::RegIntl3: r_intl3 = val[31:0];
            isar_pkg::RegOuter: r_outer = val[31:0];
            isar_pkg::RegMode:  r_mode  = val;
            isar_pkg::RegDest:  r_dest  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    function automatic logic [47:0] rnd48(input bit ext);
        if (ext) return $urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'd0;
        return 48'({$urandom, $urandom});
    endfunction

    // receiver
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 0;
                repeat (3000) @(negedge aclk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready = 0;
                repeat ($urandom_range(1, 19) - 1) @(negedge aclk);
            end else begin
                m_tready = 1;
            end
        end
    end

    // result check
    always @(posedge aclk) begin
        remap_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{src: m_tdata[63:0], dst: m_tdata[127:64], is_new: m_tdata[128],
                    last: m_tlast, status: m_tdata[130:129],
                    next_free: m_tdata[194:131]};
            if (remap_q.size() == 0) begin
                $error("unexpected transfer src=%h status=%0d", got.src, got.status);
                n_errors++;
            end else begin
                want = remap_q.pop_front();
                if (got.src !== want.src) begin
                    $error("src_addr exp %h got %h", want.src, got.src); n_errors++;
                end
                if (got.dst !== want.dst) begin
                    $error("dst_addr exp %h got %h", want.dst, got.dst); n_errors++;
                end
                if (got.is_new !== want.is_new) begin
                    $error("is_new exp %b got %b", want.is_new, got.is_new); n_errors++;
                end
                if (got.last !== want.last) begin
                    $error("last_elem exp %b got %b", want.last, got.last);
                    n_errors++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); n_errors++;
                end
                if (got.next_free !== want.next_free) begin
                    $error("next_free_addr exp %h got %h", want.next_free, got.next_free);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    localparam int N_ROWS = 31;
    row_t dir_rows [N_ROWS];

    initial begin
        int phase;
        int n;
        bit rs;
        r_base = 0; r_mode = 0; r_dest = 0; r_intl2 = 0; r_intl3 = 0; r_outer = 0;
        seen_cnt = 0; free_slot = 0; pass_iter = 0; elem_cnt = 0; lane = 0;
        walking = 0;
        for (int i = 0; i < 3; i++) begin
            walk_addr[i] = 0; pass_start[i] = 0;
        end
        dir_rows = '{
            '{0, isar_pkg::RegBase, 0, 0, 1, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 1, 1, 1, isar_pkg::StZero, 0},
            '{1, isar_pkg::RegMode, 48'h0000_0001_0005, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 1, 1, 1, isar_pkg::StMode, 0},
            '{1, isar_pkg::RegBase, 48'hFFFF_FFFF_FFFF, 0, 0, 0, isar_pkg::StOk, 0},
            '{1, isar_pkg::RegDest, 48'hFFFF_FFFF_FFF8, 0, 0, 0, isar_pkg::StOk, 0},
            '{1, isar_pkg::RegOuter, 48'h0000_FFFF_0002, 0, 0, 0, isar_pkg::StOk, 0},
            '{1, isar_pkg::RegMode, 48'h8000_000C_0003, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 1, 1, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 1, 1, isar_pkg::StOk, 64'h0000_FFFF_FFFF_FFFF},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{1, isar_pkg::RegIntl2, 48'h0000_0000_FFFF, 0, 0, 0, isar_pkg::StOk, 0},
            '{1, isar_pkg::RegIntl3, 48'h0000_7FFF_0000, 0, 0, 0, isar_pkg::StOk, 0},
            '{1, isar_pkg::RegMode, 48'h7FFF_000F_0006, 0, 0, 0, isar_pkg::StOk, 0},
            '{1, isar_pkg::RegOuter, 48'd0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 1, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 1, 0, isar_pkg::StOk, 0},
            '{1, isar_pkg::RegMode, 48'h0001_000D_FFFF, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 1, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0},
            '{0, isar_pkg::RegBase, 0, 0, 0, 0, isar_pkg::StOk, 0}
        };

        repeat (10) @(negedge aclk);
        aresetn = 1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].wr) begin
                drain();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send_item(dir_rows[i].rs);
                if (dir_rows[i].chk) begin
                    if (last_has != dir_rows[i].has) begin
                        $error("result present exp %b got %b", dir_rows[i].has, last_has);
                        n_errors++;
                    end else if (last_has && (last_remap.status != dir_rows[i].st ||
                                              last_remap.src != dir_rows[i].src)) begin
                        $error("status/src exp %0d/%h got %0d/%h", dir_rows[i].st,
                               dir_rows[i].src, last_remap.status, last_remap.src);
                        n_errors++;
                    end
                end
            end
        end

        phase = 0;
        while (n_items < N_ITEMS) begin
            drain();
            if (phase == 5) begin
                // walk long enough to overflow the seen table
                write_reg(isar_pkg::RegBase, rnd48(0));
                write_reg(isar_pkg::RegMode, {16'd8, 12'd0, isar_pkg::ModeOne, 16'd300});
                write_reg(isar_pkg::RegOuter, 48'd1);
                send_item(1);
                repeat (DEPTH + 2) send_item(0);
            end else begin
                write_reg(isar_pkg::RegBase, rnd48($urandom_range(0, 7) == 0));
                write_reg(isar_pkg::RegIntl2, rnd48($urandom_range(0, 7) == 0));
                write_reg(isar_pkg::RegIntl3, rnd48($urandom_range(0, 7) == 0));
                write_reg(isar_pkg::RegOuter, {16'd0, $urandom_range(0, 15) == 0 ? 16'hFFFF :
                                     16'($urandom), 16'($urandom_range(0, 4))});
                write_reg(isar_pkg::RegMode, {16'($urandom), 12'd0,
                                    $urandom_range(0, 9) == 0 ? 4'($urandom) :
                                    ($urandom_range(0, 2) == 0 ? isar_pkg::ModeOne :
                                     $urandom_range(0, 1) ? isar_pkg::ModeTwo
                                                          : isar_pkg::ModeThree),
                                    $urandom_range(0, 19) == 0 ? 16'd0 :
                                    16'($urandom_range(1, 12))});
                write_reg(isar_pkg::RegDest, rnd48($urandom_range(0, 7) == 0));
                if (phase == 3) hold_req = 1;
                n = $urandom_range(1, 40);
                send_item(1);
                for (int k = 0; k < n; k++) begin
                    rs = ($urandom_range(0, 29) == 0);
                    send_item(rs);
                end
            end
            if (n_items > N_ITEMS - 150) quiet = 1;
            phase++;
        end
        drain();

        if (n_errors == 0 && remap_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
